// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: command and result
// payloads, opcodes, special characters and the register map.
// ----------------------------------------------------------------------------
package tcw_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CH_BACKSPACE = 8'h08;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [15:0] RESET_CELL   = 16'h0720;

  localparam logic [3:0] RESET_FG = 4'd7;
  localparam logic [3:0] RESET_BG = 4'd0;

  // configuration register indexes
  localparam logic REG_FOREGROUND = 1'b0;
  localparam logic REG_BACKGROUND = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } cmd_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attribute;
  } result_t;

endpackage

// ===== rtl/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell console: screen store in one synchronous RAM, cursor,
// put / clear / read commands, wrap and scroll.
// ----------------------------------------------------------------------------
//  channel  | ports                        | transfer
//  ---------+------------------------------+-------------------------------
//  command  | start, busy, cmd             | start high while busy low
//  result   | done, result                 | done high for one cycle
//  config   | cfg_we, cfg_index, cfg_data  | cfg_we high, no wait
//
// Timing: a put, backspace or newline that does not scroll, a nop or an
// out-of-range read gives its result the cycle after the transfer; an in-range
// read passes through S_READ for one RAM read. A scroll walks the RAM through
// its one read port and one write port: it copies rows 1 to ROWS-1 one row up,
// then blanks the last row. A clear blanks every cell.
// After reset the RAM is swept to grey-on-black spaces with busy high. The
// result side has no stall.
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result,
  input  logic    cfg_we,
  input  logic    cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int DEPTH  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE    = ADDR_W'(COLUMNS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SCROLL = 4'b0100,
    S_FILL   = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic              rd_pend, rd_pend_next;
  logic              init, init_next;
  logic              scroll_flag, scroll_next;
  logic              done_next;
  result_t           result_next;
  logic [3:0]        fg, bg;

  logic [15:0]       mem [DEPTH];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata, rdata;

  logic [7:0]        attr;
  logic [15:0]       blank, fill_cell;
  logic [ADDR_W-1:0] cur_addr, rd_addr;
  logic              rd_in_range, finish, read_done;

  assign attr      = {bg, fg};
  assign blank     = {attr, CH_SPACE};
  assign fill_cell = init ? RESET_CELL : blank;
  assign cur_addr  = ADDR_W'(32'(row) * COLUMNS + 32'(col));
  assign rd_addr   = ADDR_W'(32'(cmd.read_row) * COLUMNS + 32'(cmd.read_col));
  assign rd_in_range = (32'(cmd.read_row) < ROWS) && (32'(cmd.read_col) < COLUMNS);
  assign busy      = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    row_next     = row;
    col_next     = col;
    ptr_next     = ptr;
    wr_addr_next = wr_addr;
    rd_pend_next = 1'b0;
    init_next    = init;
    scroll_next  = scroll_flag;
    finish       = 1'b0;
    read_done    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = ptr;
    mem_wdata    = fill_cell;
    mem_re       = 1'b0;
    mem_raddr    = ptr;

    // scroll copy: data read last cycle lands one row up
    if (rd_pend) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr;
      mem_wdata = rdata;
    end

    unique case (state)
      S_IDLE: begin
        if (start) begin
          scroll_next = 1'b0;
          priority if (cmd.opcode == OP_PUT) begin
            priority if (cmd.char_code == CH_NEWLINE) begin
              col_next = '0;
              if (row == LAST_ROW) begin
                scroll_next = 1'b1;
                ptr_next    = ROW_STRIDE;
                state_next  = S_SCROLL;
              end else begin
                row_next = row + ROW_W'(1);
                finish   = 1'b1;
              end
            end else if (cmd.char_code == CH_BACKSPACE) begin
              if (col != '0) begin
                col_next  = col - COL_W'(1);
                mem_we    = 1'b1;
                mem_waddr = cur_addr - ADDR_W'(1);
                mem_wdata = blank;
              end
              finish = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {attr, cmd.char_code};
              if (col == LAST_COL) begin
                col_next = '0;
                if (row == LAST_ROW) begin
                  scroll_next = 1'b1;
                  ptr_next    = ROW_STRIDE;
                  state_next  = S_SCROLL;
                end else begin
                  row_next = row + ROW_W'(1);
                  finish   = 1'b1;
                end
              end else begin
                col_next = col + COL_W'(1);
                finish   = 1'b1;
              end
            end
          end else if (cmd.opcode == OP_CLEAR) begin
            row_next   = '0;
            col_next   = '0;
            ptr_next   = '0;
            state_next = S_FILL;
          end else if (cmd.opcode == OP_READ) begin
            if (rd_in_range) begin
              mem_re     = 1'b1;
              mem_raddr  = rd_addr;
              state_next = S_READ;
            end else begin
              finish = 1'b1;
            end
          end else begin
            finish = 1'b1;
          end
        end
      end
      S_READ: begin
        read_done  = 1'b1;
        finish     = 1'b1;
        state_next = S_IDLE;
      end
      S_SCROLL: begin
        mem_re       = 1'b1;
        mem_raddr    = ptr;
        rd_pend_next = 1'b1;
        wr_addr_next = ptr - ROW_STRIDE;
        if (ptr == LAST_ADDR) begin
          ptr_next   = LAST_ROW_BASE;
          state_next = S_FILL;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
        end
      end
      S_FILL: begin
        // wait out the last copy write before blanking
        if (!rd_pend) begin
          mem_we    = 1'b1;
          mem_waddr = ptr;
          mem_wdata = fill_cell;
          if (ptr == LAST_ADDR) begin
            state_next = S_IDLE;
            if (init) begin
              init_next = 1'b0;
            end else begin
              finish = 1'b1;
            end
          end else begin
            ptr_next = ptr + ADDR_W'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    done_next                   = finish;
    result_next.cursor_position = 11'(32'(row_next) * COLUMNS + 32'(col_next));
    result_next.cursor_row      = 5'(32'(row_next));
    result_next.cursor_col      = 7'(32'(col_next));
    result_next.scrolled        = scroll_next;
    result_next.cell_char       = read_done ? rdata[7:0]  : 8'h00;
    result_next.cell_attribute  = read_done ? rdata[15:8] : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      init        <= 1'b1;
      row         <= '0;
      col         <= '0;
      ptr         <= '0;
      rd_pend     <= 1'b0;
      scroll_flag <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      init        <= init_next;
      row         <= row_next;
      col         <= col_next;
      ptr         <= ptr_next;
      rd_pend     <= rd_pend_next;
      scroll_flag <= scroll_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= wr_addr_next;
    result  <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= RESET_FG;
      bg <= RESET_BG;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOREGROUND: fg <= cfg_data;
        REG_BACKGROUND: bg <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for text_console_writer_unit. A scoreboard keeps its own
// screen, cursor and colors, predicts one result per command transfer and
// compares every strobed result field by field. Directed corner cases come
// first, then random typing with bursts of long lines (wrap and scroll),
// newlines, backspaces, reads and rare clears under several color settings
// and sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
  import tcw_pkg::*;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int CMD_BITS     = $bits(cmd_t);
  localparam int STALL_LIMIT  = 10000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 154;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int unsigned IDLE_PCT [4] = '{0, 58, 0, 11};

  class console_scoreboard;
    logic [15:0] screen [CELLS];
    int unsigned cur_row;
    int unsigned cur_col;
    logic [3:0]  fg;
    logic [3:0]  bg;
    result_t     pending [$];
    int unsigned mismatches;

    function new();
      foreach (screen[i]) screen[i] = RESET_CELL;
      cur_row    = 0;
      cur_col    = 0;
      fg         = RESET_FG;
      bg         = RESET_BG;
      mismatches = 0;
    endfunction

    function void write_reg(logic index, logic [3:0] value);
      if (index == REG_FOREGROUND) fg = value;
      else bg = value;
    endfunction

    function logic [15:0] make_cell(logic [7:0] ch);
      return {bg, fg, ch};
    endfunction

    // past the bottom row: shift up one row and blank the last one
    function bit next_row();
      cur_row++;
      if (cur_row < ROWS) return 1'b0;
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = make_cell(CH_SPACE);
      cur_row = ROWS - 1;
      return 1'b1;
    endfunction

    function void note_command(cmd_t c);
      result_t     r;
      logic [15:0] rd_word;
      r = '0;
      case (c.opcode)
        OP_PUT: begin
          if (c.char_code == CH_NEWLINE) begin
            cur_col    = 0;
            r.scrolled = next_row();
          end else if (c.char_code == CH_BACKSPACE) begin
            if (cur_col > 0) begin
              cur_col--;
              screen[cur_row * COLUMNS + cur_col] = make_cell(CH_SPACE);
            end
          end else begin
            screen[cur_row * COLUMNS + cur_col] = make_cell(c.char_code);
            cur_col++;
            if (cur_col >= COLUMNS) begin
              cur_col    = 0;
              r.scrolled = next_row();
            end
          end
        end
        OP_CLEAR: begin
          foreach (screen[i]) screen[i] = make_cell(CH_SPACE);
          cur_row = 0;
          cur_col = 0;
        end
        OP_READ: begin
          if (c.read_row < ROWS && c.read_col < COLUMNS) begin
            rd_word          = screen[c.read_row * COLUMNS + c.read_col];
            r.cell_char      = rd_word[7:0];
            r.cell_attribute = rd_word[15:8];
          end
        end
        default: ;
      endcase
      r.cursor_position = 11'(cur_row * COLUMNS + cur_col);
      r.cursor_row      = 5'(cur_row);
      r.cursor_col      = 7'(cur_col);
      pending.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    task check_field(string name, int got, int want);
      if (got != want) report(name, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report("result with no command outstanding", got.cursor_position, 0);
        return;
      end
      want = pending.pop_front();
      check_field("cursor_position", got.cursor_position, want.cursor_position);
      check_field("cursor_row", got.cursor_row, want.cursor_row);
      check_field("cursor_col", got.cursor_col, want.cursor_col);
      check_field("scrolled", got.scrolled, want.scrolled);
      check_field("cell_char", got.cell_char, want.cell_char);
      check_field("cell_attribute", got.cell_attribute, want.cell_attribute);
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  cmd_t       cmd;
  logic       done;
  result_t    result;
  logic       cfg_we;
  logic       cfg_index;
  logic [3:0] cfg_data;

  console_scoreboard sb;
  int unsigned quiet_cycles;
  int unsigned burst_left;

  text_console_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // results are checked before a same-edge transfer is noted
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_command(cmd);
      if (done || (start && !busy) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] op, logic [7:0] ch, logic [4:0] row,
                                    logic [6:0] col);
    cmd_t c;
    c.opcode    = op;
    c.char_code = ch;
    c.read_row  = row;
    c.read_col  = col;
    return c;
  endfunction

  function automatic cmd_t random_command();
    cmd_t        c;
    int unsigned pick;
    c.opcode    = OP_PUT;
    c.char_code = 8'($urandom_range(255));
    c.read_row  = 5'($urandom_range(31));
    c.read_col  = 7'($urandom_range(127));
    // long runs of text: wraps and scrolls
    if (burst_left > 0) begin
      burst_left--;
      while (c.char_code == CH_NEWLINE || c.char_code == CH_BACKSPACE)
        c.char_code = 8'($urandom_range(255));
      return c;
    end
    pick = $urandom_range(999);
    if (pick < 3) begin
      c.opcode = OP_CLEAR;
    end else if (pick < 20) begin
      c.opcode = OP_NOP;
    end else if (pick < 60) begin
      burst_left = $urandom_range(170, 60);
    end else if (pick < 500) begin
      // random byte as is
    end else if (pick < 620) begin
      c.char_code = CH_NEWLINE;
    end else if (pick < 700) begin
      c.char_code = CH_BACKSPACE;
    end else begin
      c.opcode = OP_READ;
      pick     = $urandom_range(99);
      if (pick < 45) begin
        c.read_row = 5'(sb.cur_row);
        c.read_col = 7'($urandom_range(COLUMNS - 1));
      end else if (pick < 85) begin
        c.read_row = 5'($urandom_range(ROWS - 1));
        c.read_col = 7'($urandom_range(COLUMNS - 1));
      end
    end
    return c;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_command(cmd_t c, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    cmd   = c;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    cmd   = cmd_t'(CMD_BITS'($urandom));
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_config(logic index, logic [3:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(posedge clk);
    sb.write_reg(index, value);
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_data = 4'($urandom_range(15));
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_FOREGROUND;
    cfg_data   = '0;
    burst_left = 0;
    sb         = new();
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: reset contents, range edges, backspace at column 0, nop, clear
    send_command(make_cmd(OP_READ, 8'h00, 5'd0, 7'd0), 0);
    send_command(make_cmd(OP_READ, 8'hFF, 5'd24, 7'd79), 0);
    send_command(make_cmd(OP_READ, 8'h00, 5'd25, 7'd0), 0);
    send_command(make_cmd(OP_READ, 8'h00, 5'd0, 7'd80), 0);
    send_command(make_cmd(OP_READ, 8'hFF, 5'd31, 7'd127), 0);
    send_command(make_cmd(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0), 0);
    send_command(make_cmd(OP_PUT, 8'h48, 5'd31, 7'd127), 0);
    send_command(make_cmd(OP_PUT, 8'h00, 5'd0, 7'd0), 0);
    send_command(make_cmd(OP_PUT, 8'hFF, 5'd0, 7'd0), 0);
    send_command(make_cmd(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0), 0);
    send_command(make_cmd(OP_READ, 8'h00, 5'd0, 7'd1), 0);
    send_command(make_cmd(OP_READ, 8'h00, 5'd0, 7'd2), 0);
    send_command(make_cmd(OP_PUT, CH_NEWLINE, 5'd0, 7'd0), 0);
    send_command(make_cmd(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0), 0);
    send_command(make_cmd(OP_PUT, 8'h7E, 5'd0, 7'd0), 0);
    send_command(make_cmd(OP_NOP, 8'hFF, 5'd31, 7'd127), 0);
    send_command(make_cmd(OP_PUT, CH_NEWLINE, 5'd0, 7'd0), 0);
    send_command(make_cmd(OP_READ, 8'h00, 5'd1, 7'd0), 0);
    send_command(make_cmd(OP_CLEAR, 8'hFF, 5'd31, 7'd127), 0);
    send_command(make_cmd(OP_READ, 8'h00, 5'd1, 7'd0), 0);
    send_command(make_cmd(OP_PUT, 8'h0D, 5'd0, 7'd0), 0);

    // random traffic; colors change only once everything has drained
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      if (phase < 4) begin
        write_config(REG_FOREGROUND, phase[0] ? 4'h0 : 4'hF);
        write_config(REG_BACKGROUND, phase[1] ? 4'h0 : 4'hF);
      end else begin
        write_config(REG_FOREGROUND, 4'($urandom_range(15)));
        write_config(REG_BACKGROUND, 4'($urandom_range(15)));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(199) == 0) wait_drained();
        send_command(random_command(), IDLE_PCT[phase % 4]);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report("results never delivered", sb.pending.size(), 0);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
